@@ hdl/mpd_pkg.sv @@
// Shared types, codes and decode tables for the meter packet decoder.
// Used by the digit lanes, the merge stage and the top level.
package mpd_pkg;

  // Status codes, first failing check wins
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_TERM   = 3'd1;
  localparam logic [2:0] ST_AUTO_MAN   = 3'd2;
  localparam logic [2:0] ST_BAD_DIGITS = 3'd3;
  localparam logic [2:0] ST_BAD_RANGE  = 3'd4;
  localparam logic [2:0] ST_BAD_MODE   = 3'd5;

  // Limit marks
  localparam logic [1:0] LIM_NONE  = 2'd0;
  localparam logic [1:0] LIM_OVER  = 2'd1;
  localparam logic [1:0] LIM_UNDER = 2'd2;

  // Characters of the frame
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] CHR_LT    = 8'h3C;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;

  // Function codes with special handling
  localparam logic [3:0] MODE_CONT  = 4'd10;
  localparam logic [3:0] MODE_DIODE = 4'd11;
  localparam logic [3:0] MODE_FREQ  = 4'd12;

  // Duty cycle replaces frequency when the sign bit is set
  localparam logic [3:0] QTY_DUTY     = 4'd7;
  localparam logic [3:0] UNIT_PERCENT = 4'd8;

  localparam int NUM_LANES = 5;
  localparam int MAG_W     = 17;

  // Continuity threshold: display value above this (in counts) is open
  localparam logic [MAG_W-1:0] CONT_LIMIT = 17'd60;
  localparam logic [MAG_W-1:0] MAG_MAX    = '1;

  // Decimal exponent per function (row) and range (column)
  localparam logic signed [4:0] EXP_TABLE [16][8] = '{
    '{-5,   0,   0,   0,  0,  0,  0,  0},
    '{ 0,  -4,  -3,  -2, -1,  0,  0,  0},
    '{ 0,  -4,  -3,  -2, -1,  0,  0,  0},
    '{-5,   0,   0,   0,  0,  0,  0,  0},
    '{ 0,  -1,   0,   1,  2,  3,  4,  0},
    '{ 0, -12, -11, -10, -9, -8, -7, -6},
    '{-1,   0,   0,   0,  0,  0,  0,  0},
    '{-8,  -7,   0,   0,  0,  0,  0,  0},
    '{-6,  -5,   0,   0,  0,  0,  0,  0},
    '{ 0,  -3,   0,   0,  0,  0,  0,  0},
    '{-1,   0,   0,   0,  0,  0,  0,  0},
    '{-4,   0,   0,   0,  0,  0,  0,  0},
    '{-3,  -2,  -1,   0,  1,  2,  3,  4},
    '{-1,   0,   0,   0,  0,  0,  0,  0},
    '{ 0,   0,   0,   0,  0,  0,  0,  0},
    '{-2,   0,   0,   0,  0,  0,  0,  0}
  };

  localparam logic [3:0] MODE_QTY [16] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd2, 4'd4, 4'd5, 4'd1,
    4'd1, 4'd1, 4'd6, 4'd0, 4'd3, 4'd5, 4'd8, 4'd1
  };

  localparam logic [3:0] MODE_UNIT [16] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd2, 4'd4, 4'd5, 4'd1,
    4'd1, 4'd1, 4'd7, 4'd0, 4'd3, 4'd6, 4'd9, 4'd8
  };

  // Per-character findings of one lane
  typedef struct packed {
    logic       is_dig;
    logic [3:0] nib;
    logic       is_colon;
    logic       is_lt;
    logic       is_zero;
  } lane_t;

  // Decoded item between merge and the final stage
  typedef struct packed {
    logic [2:0]        status;
    logic [1:0]        limit;
    logic [MAG_W-1:0]  mag;
    logic              neg;
    logic              cont;
    logic [MAG_W-1:0]  thr;
    logic signed [4:0] expo;
    logic [3:0]        qty;
    logic [3:0]        unit;
    logic              ac;
    logic              dc;
    logic              autor;
    logic              diode;
  } merge_t;

  // Largest display count that still reads as closed for a given exponent.
  // value * 10^e > 60 is the same as count > floor(60 / 10^e) for e >= 0.
  function automatic logic [MAG_W-1:0] cont_thr(input logic signed [4:0] e);
    logic [MAG_W-1:0] t;
    priority if (e == 5'sd0)  t = CONT_LIMIT;
    else if (e == 5'sd1)      t = 17'd6;
    else if (e > 5'sd1)       t = '0;
    else if (e == -5'sd1)     t = 17'd600;
    else if (e == -5'sd2)     t = 17'd6000;
    else if (e == -5'sd3)     t = 17'd60000;
    else                      t = MAG_MAX;
    return t;
  endfunction

endpackage

@@ hdl/multimeter_packet_decoder_core.sv @@
// Top level of the meter packet decoder: five digit lanes, merge stage and
// output register. Depends on mpd_pkg, mpd_digit_lane and mpd_merge.
//
// Channel | Signals              | Direction | Meaning
// in      | in_valid / in_stall  | request   | one whole 11-byte frame
// out     | out_valid / out_stall| result    | decoded value and status
//
// One frame per cycle while in_stall is low; a request reaches out_valid via s1 and s2.
// Stages: lane classify -> merge/accumulate -> sign, continuity, output reg.
// A held result (out_valid with out_stall) freezes all three register stages
// together and raises in_stall.
// rst clears the stage valid bits only; payload registers are not reset.
module multimeter_packet_decoder_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         digit_0,
  input  logic [7:0]         digit_1,
  input  logic [7:0]         digit_2,
  input  logic [7:0]         digit_3,
  input  logic [7:0]         digit_4,
  input  logic [7:0]         range_byte,
  input  logic [7:0]         mode_byte,
  input  logic [7:0]         state_one,
  input  logic [7:0]         state_two,
  input  logic [7:0]         end_cr,
  input  logic [7:0]         end_lf,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic signed [17:0] mantissa,
  output logic signed [4:0]  exponent,
  output logic [3:0]         quantity,
  output logic [3:0]         unit,
  output logic [1:0]         limit_mark,
  output logic               flag_ac,
  output logic               flag_dc,
  output logic               flag_rms,
  output logic               flag_autorange,
  output logic               flag_diode
);
  import mpd_pkg::*;

  logic       adv;
  logic [7:0] chars [NUM_LANES];
  lane_t      lane_info [NUM_LANES];

  // Stage 1 registers
  logic       s1_valid;
  lane_t      s1_lanes [NUM_LANES];
  logic [7:0] s1_range, s1_mode, s1_cr, s1_lf;
  logic [1:0] s1_state_one;
  logic [2:0] s1_state_two;

  // Stage 2 registers
  merge_t     merged;
  logic       s2_valid;
  merge_t     s2;

  logic              open_c;
  logic [17:0]       mag_ext;
  logic [17:0]       mant_next;

  // Whole pipeline moves unless a finished result is held
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  assign chars[0] = digit_0;
  assign chars[1] = digit_1;
  assign chars[2] = digit_2;
  assign chars[3] = digit_3;
  assign chars[4] = digit_4;

  // Digit lanes
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    mpd_digit_lane u_lane (
      .char_in (chars[g]),
      .info    (lane_info[g])
    );
  end

  // Stage 1: lane findings and header bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
    if (adv) begin
      s1_lanes     <= lane_info;
      s1_range     <= range_byte;
      s1_mode      <= mode_byte;
      s1_cr        <= end_cr;
      s1_lf        <= end_lf;
      s1_state_one <= state_one[1:0];
      s1_state_two <= state_two[2:0];
    end
  end

  mpd_merge u_merge (
    .lanes      (s1_lanes),
    .range_byte (s1_range),
    .mode_byte  (s1_mode),
    .state_one  (s1_state_one),
    .state_two  (s1_state_two),
    .end_cr     (s1_cr),
    .end_lf     (s1_lf),
    .res        (merged)
  );

  // Stage 2: merged decode
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
    if (adv) begin
      s2 <= merged;
    end
  end

  // Final stage: sign and continuity reduction
  assign open_c  = (s2.limit != LIM_NONE) || (s2.neg && s2.mag != '0) || (s2.mag > s2.thr);
  assign mag_ext = {1'b0, s2.mag};

  always_comb begin
    if (s2.cont)     mant_next = open_c ? 18'd0 : 18'd1;
    else if (s2.neg) mant_next = 18'(-mag_ext);
    else             mant_next = mag_ext;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_valid;
    end
    if (adv) begin
      status         <= s2.status;
      mantissa       <= $signed(mant_next);
      exponent       <= s2.expo;
      quantity       <= s2.qty;
      unit           <= s2.unit;
      limit_mark     <= s2.limit;
      flag_ac        <= s2.ac;
      flag_dc        <= s2.dc;
      flag_rms       <= s2.ac;
      flag_autorange <= s2.autor;
      flag_diode     <= s2.diode;
    end
  end

  // An error result carries nothing but its status
  a_err_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> mantissa == 18'sd0 && exponent == 5'sd0 &&
      quantity == 4'd0 && unit == 4'd0 && limit_mark == LIM_NONE && !flag_ac)
    else $error("error result has nonzero fields");

  // Over or under limit never shows a count
  a_limit_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && limit_mark != LIM_NONE |-> mantissa == 18'sd0)
    else $error("limit display with nonzero mantissa");

  // RMS follows AC
  a_rms: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> flag_rms == flag_ac)
    else $error("rms flag differs from ac flag");

  // A held result keeps the middle stages frozen
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(s2_valid) && $stable(s1_valid))
    else $error("pipeline moved while output was held");

endmodule

@@ hdl/mpd_digit_lane.sv @@
// One display-character lane: classifies a byte and extracts its digit.
// Depends on mpd_pkg for lane_t and character codes.
module mpd_digit_lane (
  input  logic [7:0]    char_in,
  output mpd_pkg::lane_t info
);
  import mpd_pkg::*;

  // Classify the character
  always_comb begin
    info.is_dig   = (char_in >= CHR_ZERO) && (char_in <= CHR_NINE);
    info.nib      = char_in[3:0];
    info.is_colon = (char_in == CHR_COLON);
    info.is_lt    = (char_in == CHR_LT);
    info.is_zero  = (char_in == CHR_ZERO);
  end

endmodule

@@ hdl/mpd_merge.sv @@
// Merge stage: combines the five lane results with the header bytes into
// status, limit mark, display magnitude and table lookups. Uses mpd_pkg.
module mpd_merge (
  input  mpd_pkg::lane_t lanes [mpd_pkg::NUM_LANES],
  input  logic [7:0]     range_byte,
  input  logic [7:0]     mode_byte,
  input  logic [1:0]     state_one,
  input  logic [2:0]     state_two,
  input  logic [7:0]     end_cr,
  input  logic [7:0]     end_lf,
  output mpd_pkg::merge_t res
);
  import mpd_pkg::*;

  logic             term_ok;
  logic             over, under, four, digs_ok, range_ok, mode_ok;
  logic [2:0]       status;
  logic [1:0]       limit;
  logic [2:0]       rng;
  logic [3:0]       mode;
  logic             sign, duty;
  logic [MAG_W-1:0] acc1, acc2, acc3, acc4, acc5;
  logic signed [4:0] expo;

  // Frame pattern checks
  assign term_ok  = (end_cr == CHR_CR) && (end_lf == CHR_LF);
  assign over     = lanes[0].is_colon && lanes[1].is_colon && lanes[2].is_zero &&
                    lanes[3].is_lt && lanes[4].is_colon;
  assign under    = lanes[0].is_colon && lanes[1].is_lt && lanes[2].is_zero &&
                    lanes[3].is_colon && lanes[4].is_colon;
  assign four     = lanes[4].is_colon;
  assign digs_ok  = lanes[0].is_dig && lanes[1].is_dig && lanes[2].is_dig &&
                    lanes[3].is_dig && (four || lanes[4].is_dig);
  assign range_ok = (range_byte[7:3] == 5'b00110);
  assign mode_ok  = (mode_byte[7:4] == 4'h3);

  // Status, first failure wins
  always_comb begin
    limit = LIM_NONE;
    if (over)       limit = LIM_OVER;
    else if (under) limit = LIM_UNDER;
    priority if (!term_ok)                          status = ST_BAD_TERM;
    else if (state_two[0] && state_two[1])          status = ST_AUTO_MAN;
    else if (limit == LIM_NONE && !digs_ok)         status = ST_BAD_DIGITS;
    else if (!range_ok)                             status = ST_BAD_RANGE;
    else if (!mode_ok)                              status = ST_BAD_MODE;
    else                                            status = ST_OK;
  end

  // Display count, most significant lane first
  assign acc1 = {13'd0, lanes[0].nib};
  assign acc2 = acc1 * 17'd10 + {13'd0, lanes[1].nib};
  assign acc3 = acc2 * 17'd10 + {13'd0, lanes[2].nib};
  assign acc4 = acc3 * 17'd10 + {13'd0, lanes[3].nib};
  assign acc5 = acc4 * 17'd10 + {13'd0, lanes[4].nib};

  assign rng  = range_byte[2:0];
  assign mode = mode_byte[3:0];
  assign expo = EXP_TABLE[mode][rng];
  assign sign = state_two[2];
  assign duty = (mode == MODE_FREQ) && sign;

  // Result assembly; an error clears everything but the status
  always_comb begin
    res = '0;
    res.status = status;
    if (status == ST_OK) begin
      res.limit = limit;
      res.mag   = (limit != LIM_NONE) ? '0 : (four ? acc4 : acc5);
      res.neg   = sign && !duty;
      res.cont  = (mode == MODE_CONT);
      res.thr   = cont_thr(expo);
      res.expo  = expo;
      res.qty   = duty ? QTY_DUTY : MODE_QTY[mode];
      res.unit  = duty ? UNIT_PERCENT : MODE_UNIT[mode];
      res.ac    = state_one[0];
      res.dc    = state_one[1];
      res.autor = state_two[0];
      res.diode = (mode == MODE_DIODE);
    end
  end

endmodule
